[src/kcfc_pkg.sv]
// ---------------------------------------------------------------------------
// Kicker controller package
// Shared widths, codes and record types for the kicker charge and fire
// controller.
// ---------------------------------------------------------------------------
package kcfc_pkg;

  // The longest shot is 100 times a 16-bit unit, which needs 23 bits, so a
  // 23-bit timer holds every period and shot length without saturation.
  localparam int unsigned TimerBits = 23;
  localparam int unsigned PowerBits = 7;
  localparam int unsigned UnitBits  = 16;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [PowerBits-1:0] PowerMin = PowerBits'(1);
  localparam logic [PowerBits-1:0] PowerMax = PowerBits'(100);

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SHOOT   = 2'd1,
    OP_ENABLE  = 2'd2,
    OP_DISABLE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_OFF      = 2'd0,
    MODE_CHARGING = 2'd1,
    MODE_READY    = 2'd2,
    MODE_KICKING  = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_KICK_POWER      = 3'd0,
    REG_KICK_TIME_UNIT  = 3'd1,
    REG_CHIP_TIME_UNIT  = 3'd2,
    REG_READY_PERIOD    = 3'd3,
    REG_CHARGING_PERIOD = 3'd4,
    REG_KICKING_PERIOD  = 3'd5,
    REG_OFF_PERIOD      = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [PowerBits-1:0] kick_power;
    logic [UnitBits-1:0]  kick_time_unit;
    logic [UnitBits-1:0]  chip_time_unit;
    logic [UnitBits-1:0]  ready_period;
    logic [UnitBits-1:0]  charging_period;
    logic [UnitBits-1:0]  kicking_period;
    logic [UnitBits-1:0]  off_period;
  } cfg_t;

  typedef struct packed {
    logic kick_drive;
    logic chip_drive;
    logic charge_drive;
    mode_e mode;
    logic is_charged;
    logic timer_active;
  } result_t;

endpackage

[src/kcfc_cfg_regs.sv]
// ---------------------------------------------------------------------------
// Kicker controller configuration registers
// Holds the seven setup registers written through the plain write port.
// ---------------------------------------------------------------------------
module kcfc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [kcfc_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [kcfc_pkg::CfgDataBits-1:0]    cfg_data_i,
  output kcfc_pkg::cfg_t                      cfg_o
);

  kcfc_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (kcfc_pkg::cfg_reg_e'(cfg_idx_i))
        kcfc_pkg::REG_KICK_POWER:
          cfg_d.kick_power = cfg_data_i[kcfc_pkg::PowerBits-1:0];
        kcfc_pkg::REG_KICK_TIME_UNIT:  cfg_d.kick_time_unit  = cfg_data_i;
        kcfc_pkg::REG_CHIP_TIME_UNIT:  cfg_d.chip_time_unit  = cfg_data_i;
        kcfc_pkg::REG_READY_PERIOD:    cfg_d.ready_period    = cfg_data_i;
        kcfc_pkg::REG_CHARGING_PERIOD: cfg_d.charging_period = cfg_data_i;
        kcfc_pkg::REG_KICKING_PERIOD:  cfg_d.kicking_period  = cfg_data_i;
        kcfc_pkg::REG_OFF_PERIOD:      cfg_d.off_period      = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/kcfc_core.sv]
// ---------------------------------------------------------------------------
// Kicker controller core
// Input register, mode and timer state, and the combinational update that
// turns one accepted item into one result.
// ---------------------------------------------------------------------------
module kcfc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kcfc_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          operation_i,
  input  logic                chip_select_i,
  input  logic                charge_done_n_i,
  input  logic                space_i,
  output logic                push_o,
  output kcfc_pkg::result_t   result_o
);

  typedef struct packed {
    kcfc_pkg::mode_e                   mode;
    logic                              charged;
    logic                              kick;
    logic                              chip;
    logic                              charge;
    logic [kcfc_pkg::TimerBits-1:0]    tick;
    logic [kcfc_pkg::TimerBits-1:0]    reload;
    logic                              run;
  } ctl_t;

  // Input register.
  logic       in_valid_q;
  logic [1:0] op_q;
  logic       chip_sel_q;
  logic       done_n_q;

  ctl_t st_d, st_q;
  logic advance;

  logic [kcfc_pkg::PowerBits-1:0] power;
  logic [kcfc_pkg::UnitBits-1:0]  unit;
  logic [kcfc_pkg::TimerBits-1:0] shot_len;

  function automatic ctl_t restart(ctl_t s, logic [kcfc_pkg::UnitBits-1:0] period);
    ctl_t r;
    r        = s;
    r.tick   = '0;
    r.reload = kcfc_pkg::TimerBits'(period);
    r.run    = 1'b1;
    return r;
  endfunction

  // Runs the per-mode step at timer expiry, and also as part of an enable.
  function automatic ctl_t mode_step(ctl_t s, logic done_n, kcfc_pkg::cfg_t c);
    ctl_t r;
    r = s;
    case (s.mode)
      kcfc_pkg::MODE_READY: begin
        r.charged = ~s.charged;
        r.charge  = s.charged;
        r = restart(r, c.ready_period);
      end
      kcfc_pkg::MODE_CHARGING: begin
        if (!done_n) begin
          r.charge  = 1'b0;
          r.charged = 1'b1;
          r.mode    = kcfc_pkg::MODE_READY;
        end else begin
          r.kick    = 1'b0;
          r.chip    = 1'b0;
          r.charge  = 1'b1;
          r.charged = 1'b0;
        end
        r = restart(r, c.charging_period);
      end
      kcfc_pkg::MODE_KICKING: begin
        r.kick = 1'b0;
        r.chip = 1'b0;
        r.mode = kcfc_pkg::MODE_CHARGING;
        r = restart(r, c.kicking_period);
      end
      default: begin
        r.kick   = 1'b0;
        r.chip   = 1'b0;
        r.charge = 1'b0;
        r = restart(r, c.off_period);
      end
    endcase
    return r;
  endfunction

  assign advance    = in_valid_q && space_i;
  assign in_ready_o = !in_valid_q || advance;

  // Shot length: power clamped to 1..100 times the selected unit.
  always_comb begin
    power = cfg_i.kick_power;
    if (power < kcfc_pkg::PowerMin) power = kcfc_pkg::PowerMin;
    if (power > kcfc_pkg::PowerMax) power = kcfc_pkg::PowerMax;
    unit     = chip_sel_q ? cfg_i.chip_time_unit : cfg_i.kick_time_unit;
    shot_len = kcfc_pkg::TimerBits'(power) * kcfc_pkg::TimerBits'(unit);
  end

  always_comb begin
    ctl_t t;
    t    = st_q;
    st_d = st_q;
    case (kcfc_pkg::op_e'(op_q))
      kcfc_pkg::OP_TICK: begin
        if (st_q.run) begin
          if (st_q.tick == st_q.reload) begin
            st_d = mode_step(st_q, done_n_q, cfg_i);
          end else begin
            st_d.tick = st_q.tick + kcfc_pkg::TimerBits'(1);
          end
        end
      end
      kcfc_pkg::OP_SHOOT: begin
        if (st_q.mode == kcfc_pkg::MODE_READY) begin
          st_d.mode   = kcfc_pkg::MODE_KICKING;
          st_d.charge = 1'b0;
          if (chip_sel_q) st_d.chip = 1'b1;
          else            st_d.kick = 1'b1;
          st_d.tick   = '0;
          st_d.reload = shot_len;
          st_d.run    = 1'b1;
        end
      end
      kcfc_pkg::OP_ENABLE: begin
        t.charged = 1'b0;
        t.mode    = kcfc_pkg::MODE_CHARGING;
        t.kick    = 1'b0;
        t.chip    = 1'b0;
        t.charge  = 1'b1;
        st_d = mode_step(t, done_n_q, cfg_i);
      end
      default: begin
        st_d.charged = 1'b0;
        st_d.mode    = kcfc_pkg::MODE_OFF;
        st_d.kick    = 1'b0;
        st_d.chip    = 1'b0;
        st_d.charge  = 1'b0;
        st_d.run     = 1'b0;
        st_d.tick    = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      st_q       <= '{mode: kcfc_pkg::MODE_OFF, default: '0};
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q       <= operation_i;
      chip_sel_q <= chip_select_i;
      done_n_q   <= charge_done_n_i;
    end
  end

  assign push_o                = advance;
  assign result_o.kick_drive   = st_d.kick;
  assign result_o.chip_drive   = st_d.chip;
  assign result_o.charge_drive = st_d.charge;
  assign result_o.mode         = st_d.mode;
  assign result_o.is_charged   = st_d.charged;
  assign result_o.timer_active = st_d.run;

endmodule

[src/kcfc_out_buf.sv]
// ---------------------------------------------------------------------------
// Kicker controller result buffer
// Two-entry result queue, so the core keeps taking items while a result
// waits on the output.
// ---------------------------------------------------------------------------
module kcfc_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  kcfc_pkg::result_t   data_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kcfc_pkg::result_t   data_o
);

  kcfc_pkg::result_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign space_o     = (count_q != 2'd2);
  assign data_o      = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop)      count_d = count_q + 2'd1;
    else if (pop && !push_i) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= data_i;
  end

endmodule

[src/kicker_charge_fire_controller.sv]
// ---------------------------------------------------------------------------
// Kicker charge and fire controller
// Charger and solenoid sequencer with its own period timer.
// ---------------------------------------------------------------------------
// Each transfer on the input (tick, shoot, enable or disable) yields exactly
// one result transfer carrying the drive levels, mode, charged flag and timer
// state after that item. The block takes one item per clock unless the full
// result queue holds the input. Each item sits in the input register while
// the mode update runs; its result then enters the two-entry result queue,
// which lets the input keep flowing while one result is held on the output.
// Configuration is to be written through the plain write port while no item
// is in flight; the user must ensure this, as the block does not enforce it.
module kicker_charge_fire_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kcfc_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [kcfc_pkg::CfgDataBits-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        operation_i,
  input  logic                              chip_select_i,
  input  logic                              charge_done_n_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              kick_drive_o,
  output logic                              chip_drive_o,
  output logic                              charge_drive_o,
  output logic [1:0]                        mode_o,
  output logic                              is_charged_o,
  output logic                              timer_active_o
);

  kcfc_pkg::cfg_t    cfg;
  kcfc_pkg::result_t core_result, out_result;
  logic              push, space;

  kcfc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  kcfc_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .chip_select_i   (chip_select_i),
    .charge_done_n_i (charge_done_n_i),
    .space_i         (space),
    .push_o          (push),
    .result_o        (core_result)
  );

  kcfc_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (core_result),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (out_result)
  );

  assign kick_drive_o   = out_result.kick_drive;
  assign chip_drive_o   = out_result.chip_drive;
  assign charge_drive_o = out_result.charge_drive;
  assign mode_o         = out_result.mode;
  assign is_charged_o   = out_result.is_charged;
  assign timer_active_o = out_result.timer_active;

endmodule

[src/kcfc_checker.sv]
// ---------------------------------------------------------------------------
// Kicker controller checker
// Port-level properties of the controller, bound to the top level.
// ---------------------------------------------------------------------------
module kcfc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       kick_drive_o,
  input logic       chip_drive_o,
  input logic       charge_drive_o,
  input logic [1:0] mode_o,
  input logic       is_charged_o,
  input logic       timer_active_o
);

  // Off is only entered by reset or disable, both of which stop everything.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_o == kcfc_pkg::MODE_OFF) |->
      !timer_active_o && !kick_drive_o && !chip_drive_o && !charge_drive_o)
    else $error("off mode with a drive or timer active");

  // A solenoid only fires in kicking mode, and never both at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kick_drive_o || chip_drive_o) |->
      (mode_o == kcfc_pkg::MODE_KICKING) && !(kick_drive_o && chip_drive_o))
    else $error("solenoid drive outside a shot");

  // The charger is never on while a solenoid fires.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kick_drive_o || chip_drive_o) |-> !charge_drive_o)
    else $error("charger on during a shot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({kick_drive_o, chip_drive_o, charge_drive_o, mode_o,
               is_charged_o, timer_active_o}))
    else $error("stalled result changed");

endmodule

bind kicker_charge_fire_controller kcfc_checker u_kcfc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .kick_drive_o   (kick_drive_o),
  .chip_drive_o   (chip_drive_o),
  .charge_drive_o (charge_drive_o),
  .mode_o         (mode_o),
  .is_charged_o   (is_charged_o),
  .timer_active_o (timer_active_o)
);
